// ===== design/fir_convolution_with_tail_assert.svh =====
// ---------------------------------------------------------------------------
// fir convolution with tail - assertion macros
// shared property forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef FIR_CONVOLUTION_WITH_TAIL_ASSERT_SVH
`define FIR_CONVOLUTION_WITH_TAIL_ASSERT_SVH

// condition holds on every edge out of reset
`define FCT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define FCT_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fct_pkg.sv =====
// ---------------------------------------------------------------------------
// fct_pkg
// shared types and constants of the streaming fir filter
// ---------------------------------------------------------------------------
package fct_pkg;

  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 15;
  localparam int TAPCFG_BITS = 7;
  localparam int CIDX_BITS = 6;

  typedef logic [1:0] op_t;

  localparam op_t OP_FILTER = 2'd0;
  localparam op_t OP_COEF   = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic hist_wr;
    logic coef_wr;
    logic hist_clr;
    logic tap_issue;
    logic round_en;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic mac_busy;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/fct_ctrl.sv =====
// ---------------------------------------------------------------------------
// fct_ctrl
// sequencer: item decode, tap loop, pipeline drain, round and output load
// ---------------------------------------------------------------------------
module fct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  fct_pkg::op_t      in_op,
  output logic              in_stall,
  output fct_pkg::ctl_cmd_t cmd,
  input  fct_pkg::dp_stat_t st
);
  import fct_pkg::*;

`include "fir_convolution_with_tail_assert.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_FILTER: begin
              cmd.hist_wr = 1'b1;
              state_nxt   = S_RUN;
            end
            OP_COEF:  cmd.coef_wr  = 1'b1;
            OP_CLEAR: cmd.hist_clr = 1'b1;
            default: ;
          endcase
        end
      end
      S_RUN: begin
        cmd.tap_issue = 1'b1;
        if (st.last_tap) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!st.mac_busy) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `FCT_ASSERT_NEXT(a_start_run, cmd.hist_wr, state_r == S_RUN, "filter beat did not start tap loop")
  `FCT_ASSERT_NEXT(a_drain, (state_r == S_RUN) && st.last_tap, (state_r == S_DRAIN) && st.mac_busy, "mac pipeline empty after last tap")
  `FCT_ASSERT_HOLD(a_round_idle, state_r == S_ROUND, !st.mac_busy, "rounding while mac busy")

endmodule

// ===== design/fct_dp.sv =====
// ---------------------------------------------------------------------------
// fct_dp
// coefficient and history memories, shared multiply-accumulate,
// rounding, saturation and output register
// ---------------------------------------------------------------------------
module fct_dp #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [fct_pkg::TAPCFG_BITS-1:0]          cfg_tap_count,
  input  fct_pkg::ctl_cmd_t                        cmd,
  output fct_pkg::dp_stat_t                        st,
  input  logic signed [SAMPLE_BITS-1:0]            in_sample_in,
  input  logic [fct_pkg::CIDX_BITS-1:0]            in_coef_index,
  input  logic signed [fct_pkg::COEF_BITS-1:0]     in_coef_value,
  input  logic                                     out_stall,
  output logic                                     out_valid,
  output logic signed [SAMPLE_BITS-1:0]            out_filtered_sample,
  output logic                                     out_saturated
);
  import fct_pkg::*;

`include "fir_convolution_with_tail_assert.svh"

  localparam int IDX_W  = $clog2(MAX_TAPS);
  localparam int CNT_W  = ($clog2(MAX_TAPS + 1) > TAPCFG_BITS) ?
                          $clog2(MAX_TAPS + 1) : TAPCFG_BITS;
  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + IDX_W + 1;
  localparam int RND_W  = ACC_W - FRAC_BITS;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TAPS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);
  localparam logic signed [RND_W-1:0] MAXV =
    {{(RND_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [RND_W-1:0] MINV =
    {{(RND_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

  logic [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

  logic [TAPCFG_BITS-1:0] tap_count_r;
  logic [IDX_W-1:0]       ptr_r;
  logic [CNT_W-1:0]       fill_r;
  logic [IDX_W-1:0]       rd_pos_r;
  logic [CNT_W-1:0]       j_r;

  logic                          s1_vld_r;
  logic                          hv_r;
  logic signed [COEF_BITS-1:0]   coef_q_r;
  logic signed [SAMPLE_BITS-1:0] hist_q_r;
  logic                          s2_vld_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [RND_W-1:0]       rnd_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;
  logic                          out_sat_r;

  logic [CNT_W-1:0]              tc_ext;
  logic [CNT_W-1:0]              eff_taps;
  logic [CNT_W-1:0]              ci_ext;
  logic signed [SAMPLE_BITS-1:0] hist_op;
  logic signed [PROD_W-1:0]      prod_nxt;
  logic signed [ACC_W-1:0]       rsum;

  // clamp of the tap count register
  always_comb begin
    tc_ext = CNT_W'(tap_count_r);
    if (tc_ext == '0) begin
      eff_taps = CNT_W'(1);
    end else if (tc_ext > MAX_CNT) begin
      eff_taps = MAX_CNT;
    end else begin
      eff_taps = tc_ext;
    end
  end

  assign ci_ext      = CNT_W'(in_coef_index);
  assign st.last_tap = (j_r == (eff_taps - CNT_W'(1)));
  assign st.mac_busy = s1_vld_r | s2_vld_r;
  assign st.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAPCFG_BITS'(1);
    end else if (cfg_we) begin
      tap_count_r <= cfg_tap_count;
    end
  end

  // memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && (ci_ext < MAX_CNT)) begin
      coef_mem[ci_ext[IDX_W-1:0]] <= in_coef_value;
    end
    if (cmd.tap_issue) begin
      coef_q_r <= coef_mem[j_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_wr) begin
      hist_mem[ptr_r] <= in_sample_in;
    end
    if (cmd.tap_issue) begin
      hist_q_r <= hist_mem[rd_pos_r];
    end
  end

  // history pointer, fill count and tap walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (cmd.hist_clr) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (cmd.hist_wr) begin
      ptr_r <= (ptr_r == LAST_IDX) ? '0 : ptr_r + IDX_W'(1);
      if (fill_r != MAX_CNT) begin
        fill_r <= fill_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_wr) begin
      rd_pos_r <= ptr_r;
      j_r      <= '0;
    end else if (cmd.tap_issue) begin
      rd_pos_r <= (rd_pos_r == '0) ? LAST_IDX : rd_pos_r - IDX_W'(1);
      j_r      <= j_r + CNT_W'(1);
    end
    if (cmd.tap_issue) begin
      hv_r <= (j_r < fill_r);
    end
  end

  // multiply-accumulate pipeline
  assign hist_op  = hv_r ? hist_q_r : '0;
  assign prod_nxt = coef_q_r * hist_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.tap_issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      prod_r <= prod_nxt;
    end
    if (cmd.hist_wr) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then saturate
  assign rsum = acc_r + HALF;

  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      rnd_r <= rsum[ACC_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (rnd_r > MAXV) begin
        out_data_r <= MAXV[SAMPLE_BITS-1:0];
        out_sat_r  <= 1'b1;
      end else if (rnd_r < MINV) begin
        out_data_r <= MINV[SAMPLE_BITS-1:0];
        out_sat_r  <= 1'b1;
      end else begin
        out_data_r <= rnd_r[SAMPLE_BITS-1:0];
        out_sat_r  <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_data_r;
  assign out_saturated       = out_sat_r;

  `FCT_ASSERT_ALWAYS(a_fill_bound, fill_r <= MAX_CNT, "history fill count past depth")
  `FCT_ASSERT_NEXT(a_clr_empty, cmd.hist_clr, (fill_r == '0) && (ptr_r == '0), "history clear not taken")

endmodule

// ===== design/fir_convolution_with_tail.sv =====
// ---------------------------------------------------------------------------
// fir_convolution_with_tail
// streaming direct-form fir filter with carried sample history
// ---------------------------------------------------------------------------
// One filter beat (op 0) stores its sample and returns one result,
// sum of coef[j] * x[n-j] over the taps in use, rounded from Q1.15 and
// saturated to SAMPLE_BITS with a flag. A filter beat occupies the input
// until its result is loaded: one shared multiplier walks the taps one per
// cycle over single-port coefficient and history memories, followed by a
// pipeline drain, a rounding step and the output load; the load waits while
// the previous result is still stalled. Coefficient writes (op 1) and
// history clears (op 2) are taken without a stall and return no result;
// op 3 is ignored. Taps must be written before they are used. The history
// clear is immediate and needs no sweep. cfg_ready is always high; the
// user must change tap_count only while the filter is idle (not enforced).
// ---------------------------------------------------------------------------
module fir_convolution_with_tail #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fct_pkg::TAPCFG_BITS-1:0]      cfg_tap_count,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  fct_pkg::op_t                         in_op,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_in,
  input  logic [fct_pkg::CIDX_BITS-1:0]        in_coef_index,
  input  logic signed [fct_pkg::COEF_BITS-1:0] in_coef_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_filtered_sample,
  output logic                                 out_saturated
);
  import fct_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t st;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  fct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  fct_dp #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_tap_count       (cfg_tap_count),
    .cmd                 (cmd),
    .st                  (st),
    .in_sample_in        (in_sample_in),
    .in_coef_index       (in_coef_index),
    .in_coef_value       (in_coef_value),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_filtered_sample (out_filtered_sample),
    .out_saturated       (out_saturated)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top - streaming fir filter testbench
// drives filter, coefficient, clear and unused beats against a shadow filter
// with its own coefficients, sample history and tap count, and checks every
// output beat in order; runs several tap counts with random idling on both
// channels, one long output hold-off and a drain before each tap change
// ---------------------------------------------------------------------------
module tb_top;
  import fct_pkg::*;

  localparam int SW = 16;
  localparam int TAPS_MAX = 64;
  localparam op_t OP_NONE = 2'd3;
  localparam int PHASE_BEATS = 125;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 80;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    op_t                    op;
    logic signed [SW-1:0]   smp;
    logic [CIDX_BITS-1:0]   idx;
    logic signed [15:0]     val;
    logic                   typed;
    logic signed [SW-1:0]   y;
    logic                   sat;
  } stim_row_t;

  typedef struct packed {
    logic signed [SW-1:0] y;
    logic                 sat;
  } filt_t;

  localparam int N_DIRECTED = 23;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_COEF,   16'sd0,      6'd0,  16'sd32767,  1'b0, 16'sd0,      1'b0},
    '{OP_FILTER, 16'sd32767,  6'd0,  16'sd0,      1'b1, 16'sd32766,  1'b0},
    '{OP_FILTER, -16'sd32768, 6'd0,  16'sd0,      1'b1, -16'sd32767, 1'b0},
    '{OP_FILTER, 16'sd0,      6'd0,  16'sd0,      1'b1, 16'sd0,      1'b0},
    '{OP_COEF,   16'sd0,      6'd0,  -16'sd32768, 1'b0, 16'sd0,      1'b0},
    '{OP_FILTER, -16'sd32768, 6'd0,  16'sd0,      1'b1, 16'sd32767,  1'b1},
    '{OP_FILTER, 16'sd32767,  6'd0,  16'sd0,      1'b1, -16'sd32767, 1'b0},
    '{OP_FILTER, 16'sd1,      6'd0,  16'sd0,      1'b1, -16'sd1,     1'b0},
    '{OP_FILTER, -16'sd1,     6'd0,  16'sd0,      1'b1, 16'sd1,      1'b0},
    '{OP_COEF,   16'sd0,      6'd63, -16'sd32768, 1'b0, 16'sd0,      1'b0},
    '{OP_COEF,   16'sd0,      6'd42, 16'sd21845,  1'b0, 16'sd0,      1'b0},
    '{OP_COEF,   16'sd0,      6'd21, -16'sd21846, 1'b0, 16'sd0,      1'b0},
    '{OP_COEF,   16'sd0,      6'd0,  16'sd16384,  1'b0, 16'sd0,      1'b0},
    '{OP_FILTER, 16'sd1,      6'd0,  16'sd0,      1'b1, 16'sd1,      1'b0},
    '{OP_FILTER, -16'sd1,     6'd0,  16'sd0,      1'b1, 16'sd0,      1'b0},
    '{OP_FILTER, 16'sd3,      6'd0,  16'sd0,      1'b1, 16'sd2,      1'b0},
    '{OP_NONE,   -16'sd1,     6'd63, -16'sd1,     1'b0, 16'sd0,      1'b0},
    '{OP_CLEAR,  16'sd0,      6'd0,  16'sd0,      1'b0, 16'sd0,      1'b0},
    '{OP_FILTER, 16'sd12345,  6'd0,  16'sd0,      1'b1, 16'sd6173,   1'b0},
    '{OP_FILTER, -16'sd12345, 6'd0,  16'sd0,      1'b0, 16'sd0,      1'b0},
    '{OP_COEF,   16'sd0,      6'd0,  16'sd0,      1'b0, 16'sd0,      1'b0},
    '{OP_FILTER, 16'sd32767,  6'd0,  16'sd0,      1'b1, 16'sd0,      1'b0},
    '{OP_FILTER, -16'sd32768, 6'd0,  16'sd0,      1'b0, 16'sd0,      1'b0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [TAPCFG_BITS-1:0] cfg_tap_count;
  logic                   in_valid;
  logic                   in_stall;
  op_t                    in_op;
  logic signed [SW-1:0]   in_sample_in;
  logic [CIDX_BITS-1:0]   in_coef_index;
  logic signed [15:0]     in_coef_value;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [SW-1:0]   out_filtered_sample;
  logic                   out_saturated;

  fir_convolution_with_tail #(
    .MAX_TAPS    (TAPS_MAX),
    .SAMPLE_BITS (SW)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_tap_count       (cfg_tap_count),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_sample_in        (in_sample_in),
    .in_coef_index       (in_coef_index),
    .in_coef_value       (in_coef_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_filtered_sample (out_filtered_sample),
    .out_saturated       (out_saturated)
  );

  // shadow filter state
  logic signed [15:0]     coef_shadow [TAPS_MAX];
  logic signed [SW-1:0]   hist_shadow [TAPS_MAX];
  logic [5:0]             hist_ptr;
  logic [TAPCFG_BITS-1:0] tap_shadow;

  filt_t pending_filtered [$];
  int    mismatches;
  int    quiet_cycles;
  bit    calm;
  bit    hold_req;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic bit predict_beat(input stim_row_t r, output filt_t res);
    longint acc;
    longint y;
    int     n;
    int     k;
    res = '0;
    case (r.op)
      OP_COEF: begin
        coef_shadow[r.idx] = r.val;
        return 1'b0;
      end
      OP_CLEAR: begin
        foreach (hist_shadow[k]) hist_shadow[k] = '0;
        hist_ptr = '0;
        return 1'b0;
      end
      OP_FILTER: begin
        n = (tap_shadow < 1) ? 1 : (tap_shadow > TAPS_MAX) ? TAPS_MAX : int'(tap_shadow);
        hist_shadow[hist_ptr] = r.smp;
        acc = 0;
        for (k = 0; k < n; k++)
          acc += longint'(coef_shadow[k]) * longint'(hist_shadow[6'(int'(hist_ptr) - k)]);
        hist_ptr = hist_ptr + 6'd1;
        y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (y > 32767) begin
          res.y = 16'sh7fff;
          res.sat = 1'b1;
        end else if (y < -32768) begin
          res.y = 16'sh8000;
          res.sat = 1'b1;
        end else begin
          res.y = SW'(y);
          res.sat = 1'b0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_word();
    logic signed [15:0] w;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: w = 16'sh7fff;
        1: w = 16'sh8000;
        2: w = 16'sh0000;
        default: w = 16'shffff;
      endcase
    end else begin
      w = 16'($urandom);
    end
    return w;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t r;
    int pick;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < 72) r.op = OP_FILTER;
    else if (pick < 87) r.op = OP_COEF;
    else if (pick < 93) r.op = OP_CLEAR;
    else r.op = OP_NONE;
    r.smp = rand_word();
    r.idx = 6'($urandom);
    r.val = rand_word();
    return r;
  endfunction

  task automatic send_beat(input stim_row_t r);
    filt_t res;
    bit    taken;
    if (!calm) begin
      while ($urandom_range(0, 99) < 9) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_op         <= r.op;
    in_sample_in  <= r.smp;
    in_coef_index <= r.idx;
    in_coef_value <= r.val;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (predict_beat(r, res)) begin
      if (r.typed) begin
        res.y = r.y;
        res.sat = r.sat;
      end
      pending_filtered.push_back(res);
    end
  endtask

  // wait for every output beat, then let the last beat finish inside the block
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_taps(input logic [TAPCFG_BITS-1:0] v);
    bit taken;
    settle();
    cfg_valid     <= 1'b1;
    cfg_tap_count <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid  <= 1'b0;
    tap_shadow = v;
  endtask

  // output side
  initial begin
    filt_t exp;
    int    hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_filtered.size() == 0) begin
          $error("unexpected output beat: filtered_sample %0d, saturated %0b",
                 out_filtered_sample, out_saturated);
          mismatches++;
        end else begin
          exp = pending_filtered.pop_front();
          if (out_filtered_sample !== exp.y) begin
            $error("filtered_sample: expected %0d, got %0d", exp.y, out_filtered_sample);
            mismatches++;
          end
          if (out_saturated !== exp.sat) begin
            $error("saturated: expected %0b, got %0b", exp.sat, out_saturated);
            mismatches++;
          end
        end
      end
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 9);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int p;
    int i;
    logic [TAPCFG_BITS-1:0] tap_val;
    stim_row_t r;
    logic [TAPCFG_BITS-1:0] tap_plan [8];
    tap_plan = '{7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd1, 7'd100, 7'd33};
    mismatches = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    foreach (coef_shadow[i]) coef_shadow[i] = '0;
    foreach (hist_shadow[i]) hist_shadow[i] = '0;
    hist_ptr = '0;
    tap_shadow = 7'd1;
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_tap_count <= '0;
    in_valid      <= 1'b0;
    in_op         <= OP_FILTER;
    in_sample_in  <= '0;
    in_coef_index <= '0;
    in_coef_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at the reset tap count
    for (i = 0; i < N_DIRECTED; i++) send_beat(DIRECTED[i]);
    settle();

    // load every tap before any longer response is used
    for (i = 0; i < TAPS_MAX; i++) begin
      r = '0;
      r.op = OP_COEF;
      r.idx = 6'(i);
      r.val = rand_word();
      r.smp = rand_word();
      send_beat(r);
    end

    for (p = 0; p < 10; p++) begin
      tap_val = (p < 8) ? tap_plan[p] : 7'($urandom_range(3, 63));
      set_taps(tap_val);
      calm = (p == 4);
      for (i = 0; i < PHASE_BEATS; i++) begin
        if (p == 1 && i == 20) hold_req = 1'b1;
        send_beat(rand_row());
      end
    end
    settle();

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/fct_pkg.sv
design/fct_ctrl.sv
design/fct_dp.sv
design/fir_convolution_with_tail.sv
sim/tb_top.sv
